// ===== rtl/ssd_pkg.sv =====
// Package for the signed shift-subtract divider: operand width and the
// per-stage lane payload. No dependencies.
package ssd_pkg;

  localparam int unsigned Width = 32;

  typedef logic [Width-1:0] word_t;

  // Payload carried down the divider pipeline alongside each valid bit.
  typedef struct packed {
    word_t rem;  // partial remainder, below the divisor magnitude unless the divisor is zero
    word_t nq;   // dividend bits still to consume, quotient bits shifted in
    word_t den;  // divisor magnitude
    logic  neg;  // operand signs differ
    logic  dbz;  // divisor was zero
    logic  ovf;  // most negative value divided by minus one
  } lane_t;

endpackage

// ===== rtl/ssd_stage.sv =====
// One restoring compare-subtract step of the divider pipeline.
// Depends on ssd_pkg for the lane payload type.
module ssd_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_valid,
  input  ssd_pkg::lane_t in_lane,
  output logic          out_valid,
  output ssd_pkg::lane_t out_lane
);
  import ssd_pkg::*;

  logic          valid_r;
  lane_t         lane_r;
  lane_t         lane_nxt;
  logic [Width:0] trial;
  logic [Width:0] diff;
  logic          ge;

  // Bring down the next dividend bit, subtract the divisor where it fits.
  always_comb begin
    trial    = {in_lane.rem, in_lane.nq[Width-1]};
    diff     = trial - {1'b0, in_lane.den};
    ge       = (trial >= {1'b0, in_lane.den});
    lane_nxt = in_lane;
    lane_nxt.rem = ge ? diff[Width-1:0] : trial[Width-1:0];
    lane_nxt.nq  = {in_lane.nq[Width-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane_r <= lane_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_lane  = lane_r;

endmodule

// ===== rtl/signed_shift_subtract_divider.sv =====
// Top level of the pipelined signed shift-subtract divider.
// Depends on ssd_pkg and ssd_stage.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | in_valid, in_stall, in_dividend,        | in
//           | in_divisor                              |
//   result  | out_valid, out_stall, out_quotient,     | out
//           | out_divide_by_zero, out_overflow        |
//
// One item enters per cycle while in_stall is low; each result passes through
// one register for the operand magnitudes, 32 compare-subtract stages (one
// quotient bit each) and one register for sign fix-up.
// Reset (rst_n low, synchronous) clears every stage valid bit; payload keeps.
// Stalls collapse bubbles: a stage loads whenever it is empty or the stage
// after it moves, so in_stall rises only when every stage holds an item.
module signed_shift_subtract_divider (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [ssd_pkg::Width-1:0]   in_dividend,
  input  logic signed [ssd_pkg::Width-1:0]   in_divisor,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [ssd_pkg::Width-1:0]   out_quotient,
  output logic                               out_divide_by_zero,
  output logic                               out_overflow
);
  import ssd_pkg::*;

  localparam word_t SignBit  = {1'b1, {(Width-1){1'b0}}};
  localparam word_t AllOnes  = {Width{1'b1}};

  // valid[0] / lane[0] is the operand register, valid[k] is step stage k.
  logic [Width:0]  valid;
  lane_t           lane [Width+1];
  logic [Width+1:0] rdy;

  lane_t           in_lane_nxt;
  logic            v0_r;
  lane_t           lane0_r;

  logic            out_valid_r;
  word_t           quot_r;
  word_t           quot_nxt;
  logic            dbz_r;
  logic            ovf_r;

  // Ready chain: a stage may load when it is empty or its successor moves.
  always_comb begin
    rdy[Width+1] = !out_valid_r || !out_stall;
    for (int k = Width; k >= 0; k--) begin
      rdy[k] = !valid[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];

  // Reduce operands to magnitudes and flag the special cases up front.
  always_comb begin
    in_lane_nxt.rem = '0;
    in_lane_nxt.nq  = in_dividend[Width-1] ? (word_t'(0) - word_t'(in_dividend))
                                           : word_t'(in_dividend);
    in_lane_nxt.den = in_divisor[Width-1] ? (word_t'(0) - word_t'(in_divisor))
                                          : word_t'(in_divisor);
    in_lane_nxt.neg = in_dividend[Width-1] ^ in_divisor[Width-1];
    in_lane_nxt.dbz = (in_divisor == '0);
    in_lane_nxt.ovf = (word_t'(in_dividend) == SignBit) && (word_t'(in_divisor) == AllOnes);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (rdy[0]) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      lane0_r <= in_lane_nxt;
    end
  end

  assign valid[0] = v0_r;
  assign lane[0]  = lane0_r;

  // One quotient bit per stage, most significant first.
  for (genvar k = 1; k <= Width; k++) begin : g_step
    ssd_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (rdy[k]),
      .in_valid (valid[k-1]),
      .in_lane  (lane[k-1]),
      .out_valid(valid[k]),
      .out_lane (lane[k])
    );
  end

  // Apply the sign, drop the quotient on a zero divisor.
  always_comb begin
    if (lane[Width].dbz) begin
      quot_nxt = '0;
    end else if (lane[Width].neg) begin
      quot_nxt = word_t'(0) - lane[Width].nq;
    end else begin
      quot_nxt = lane[Width].nq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy[Width+1]) begin
      out_valid_r <= valid[Width];
    end
  end

  // Hold the result while the consumer stalls.
  always_ff @(posedge clk) begin
    if (rdy[Width+1]) begin
      quot_r <= quot_nxt;
      dbz_r  <= lane[Width].dbz;
      ovf_r  <= lane[Width].ovf;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_quotient       = quot_r;
  assign out_divide_by_zero = dbz_r;
  assign out_overflow       = ovf_r;

  // A zero divisor yields a zero quotient and never overflow.
  a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && dbz_r |-> (quot_r == '0) && !ovf_r)
    else $error("zero divisor result not cleared");

  // An overflowed result wraps to the most negative value.
  a_ovf_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ovf_r |-> (quot_r == SignBit))
    else $error("overflow result did not wrap");

  // Input back-pressure only when the whole pipeline is full.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&valid) && out_valid_r && out_stall)
    else $error("input stalled with a bubble in the pipeline");

  // A stalled result stays on the output the next cycle.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(quot_r))
    else $error("stalled result lost");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for signed_shift_subtract_divider: directed rows,
// then randomized operands, with random idling on both channels.
// Depends on ssd_pkg and the divider RTL only.
`timescale 1ns / 1ps

module tb;
  import ssd_pkg::*;

  localparam word_t MOST_NEG  = 32'h8000_0000;
  localparam word_t MOST_POS  = 32'h7fff_ffff;
  localparam word_t MINUS_ONE = 32'hffff_ffff;
  localparam int    PIPE_DEPTH    = 34;   // divider pipeline depth, used for the drain wait
  localparam int    RANDOM_ITEMS  = 1075;
  localparam int    IDLE_PERCENT  = 23;
  localparam int    HOLD_CYCLES   = 160;  // long receiver hold-off
  localparam int    HOLD_AT       = 250;  // results checked before the hold-off
  localparam int    CALM_FIRST    = 400;  // random items run without any idling
  localparam int    CALM_LAST     = 700;
  localparam int    MAX_PRINTS    = 40;
  localparam bit    TYPED   = 1'b1;       // row carries its own expected result
  localparam bit    PREDICT = 1'b0;       // row is checked against the predictor

  typedef struct packed {
    word_t quotient;
    logic  divide_by_zero;
    logic  overflow;
  } div_result_t;

  typedef struct packed {
    word_t       dividend;
    word_t       divisor;
    bit          typed;
    div_result_t result;
  } directed_row_t;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  word_t in_dividend;
  word_t in_divisor;
  logic  out_valid;
  logic  out_stall;
  word_t out_quotient;
  logic  out_divide_by_zero;
  logic  out_overflow;

  div_result_t quotients_due[$];
  int          mismatches   = 0;
  int          items_sent   = 0;
  int          results_seen = 0;
  int          zero_divides = 0;
  int          overflows    = 0;
  int          input_holds  = 0;
  bit          calm_phase   = 1'b0;   // suppresses random idling on both sides

  signed_shift_subtract_divider uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_dividend        (in_dividend),
    .in_divisor         (in_divisor),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_quotient       (out_quotient),
    .out_divide_by_zero (out_divide_by_zero),
    .out_overflow       (out_overflow)
  );

  // Directed rows: extremes, every sign pairing, zero divisors, the wrapping
  // case of most negative over minus one, and most negative operands that
  // divide normally. Rows marked PREDICT go through the predictor.
  directed_row_t directed_rows [25] = '{
    '{32'd0,       32'd1,       TYPED,   '{32'd0,       1'b0, 1'b0}},
    '{32'd7,       32'd2,       PREDICT, '{32'd0,       1'b0, 1'b0}},
    '{-32'sd7,     32'd2,       PREDICT, '{32'd0,       1'b0, 1'b0}},
    '{32'd7,       -32'sd2,     PREDICT, '{32'd0,       1'b0, 1'b0}},
    '{-32'sd7,     -32'sd2,     PREDICT, '{32'd0,       1'b0, 1'b0}},
    '{MOST_POS,    32'd1,       TYPED,   '{MOST_POS,    1'b0, 1'b0}},
    '{MOST_POS,    MINUS_ONE,   TYPED,   '{MOST_NEG + 1, 1'b0, 1'b0}},
    '{MOST_NEG,    32'd1,       TYPED,   '{MOST_NEG,    1'b0, 1'b0}},
    '{MOST_NEG,    MINUS_ONE,   TYPED,   '{MOST_NEG,    1'b0, 1'b1}},
    '{MOST_NEG,    MOST_NEG,    TYPED,   '{32'd1,       1'b0, 1'b0}},
    '{MOST_POS,    MOST_NEG,    TYPED,   '{32'd0,       1'b0, 1'b0}},
    '{MOST_NEG,    MOST_POS,    PREDICT, '{32'd0,       1'b0, 1'b0}},
    '{32'd5,       32'd0,       TYPED,   '{32'd0,       1'b1, 1'b0}},
    '{32'd0,       32'd0,       TYPED,   '{32'd0,       1'b1, 1'b0}},
    '{MOST_NEG,    32'd0,       TYPED,   '{32'd0,       1'b1, 1'b0}},
    '{MINUS_ONE,   32'd0,       TYPED,   '{32'd0,       1'b1, 1'b0}},
    '{MOST_NEG,    32'd2,       PREDICT, '{32'd0,       1'b0, 1'b0}},
    '{32'd1,       MOST_POS,    PREDICT, '{32'd0,       1'b0, 1'b0}},
    '{MINUS_ONE,   32'd1,       TYPED,   '{MINUS_ONE,   1'b0, 1'b0}},
    '{32'd100,     32'd7,       PREDICT, '{32'd0,       1'b0, 1'b0}},
    '{-32'sd100,   32'd7,       PREDICT, '{32'd0,       1'b0, 1'b0}},
    '{MINUS_ONE,   MINUS_ONE,   TYPED,   '{32'd1,       1'b0, 1'b0}},
    '{MOST_POS,    MOST_POS,    TYPED,   '{32'd1,       1'b0, 1'b0}},
    '{32'd1,       MINUS_ONE,   TYPED,   '{MINUS_ONE,   1'b0, 1'b0}},
    '{MOST_NEG,    -32'sd2,     PREDICT, '{32'd0,       1'b0, 1'b0}}
  };

  // Predictor: restoring long division on the magnitudes, one quotient bit
  // per step from the top, then sign fix-up. A most negative operand keeps
  // its magnitude 2^31 as an unsigned value.
  function automatic div_result_t signed_quotient(word_t dividend, word_t divisor);
    div_result_t res;
    word_t       mag_n;
    word_t       mag_d;
    word_t       q;
    logic [32:0] rem;
    mag_n = dividend[Width-1] ? -dividend : dividend;
    mag_d = divisor[Width-1]  ? -divisor  : divisor;
    q     = '0;
    rem   = '0;
    res   = '0;
    if (divisor == '0) begin
      res.divide_by_zero = 1'b1;
      return res;
    end
    for (int i = Width - 1; i >= 0; i--) begin
      rem = {rem[31:0], mag_n[i]};
      if (rem >= {1'b0, mag_d}) begin
        rem  = rem - {1'b0, mag_d};
        q[i] = 1'b1;
      end
    end
    res.quotient = (dividend[Width-1] ^ divisor[Width-1]) ? -q : q;
    res.overflow = (dividend == MOST_NEG) && (divisor == MINUS_ONE);
    return res;
  endfunction

  // Random operand: mostly full-range words, with a share of small values,
  // variable magnitudes and the special values (zero, +-1, the extremes).
  function automatic word_t random_operand();
    word_t v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0:       v = '0;
          1:       v = 32'd1;
          2:       v = MINUS_ONE;
          3:       v = MOST_NEG;
          4:       v = MOST_POS;
          default: v = MOST_NEG + 1;
        endcase
      end
      1, 2: v = $urandom_range(0, 255);
      3, 4: v = $urandom >> $urandom_range(0, 31);
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 1) && v != MOST_NEG) v = -v;
    return v;
  endfunction

  // One line per mismatch; printing is capped, counting is not.
  task automatic report_mismatch(string what, word_t got, word_t want);
    if (mismatches < MAX_PRINTS)
      $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Offer one item after an optional random gap, hold it until accepted,
  // then queue its expected result.
  task automatic send_item(word_t dividend, word_t divisor, div_result_t want);
    while (!calm_phase && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_dividend <= dividend;
    in_divisor  <= divisor;
    @(posedge clk);
    while (in_stall) begin
      input_holds++;
      @(posedge clk);
    end
    quotients_due.push_back(want);
    items_sent++;
  endtask

  // Clock: 12 ns period.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sender: reset, directed rows, random items, then drain.
  initial begin
    word_t       a;
    word_t       b;
    div_result_t want;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_dividend = '0;
    in_divisor  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      want = directed_rows[i].typed ? directed_rows[i].result
                                    : signed_quotient(directed_rows[i].dividend,
                                                      directed_rows[i].divisor);
      send_item(directed_rows[i].dividend, directed_rows[i].divisor, want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Run a long stretch with no idling on either side.
      calm_phase = (n >= CALM_FIRST) && (n < CALM_LAST);
      a = random_operand();
      b = ($urandom_range(0, 49) == 0) ? word_t'(0) : random_operand();
      // Now and then aim straight at the wrapping case.
      if ($urandom_range(0, 99) == 0) begin
        a = MOST_NEG;
        b = MINUS_ONE;
      end
      send_item(a, b, signed_quotient(a, b));
    end
    calm_phase = 1'b0;
    in_valid <= 1'b0;

    // Drain: wait out every outstanding result, then a pipeline's worth more
    // so any stray result has a chance to show up.
    while (quotients_due.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);

    $display("Divided %0d items; %0d results checked, %0d by zero, %0d wrapped.",
             items_sent, results_seen, zero_divides, overflows);
    $display("Input held back by the divider on %0d cycles.", input_holds);
    if (mismatches == 0) begin
      $display("signed_shift_subtract_divider verification clean");
    end else begin
      $display("signed_shift_subtract_divider verification failed");
    end
    $finish;
  end

  // Receiver: check each accepted result against the oldest expectation and
  // drive out_stall for the next cycle. The long hold-off is counted here.
  initial begin
    div_result_t want;
    int          hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && !out_stall) begin
        results_seen++;
        if (quotients_due.size() == 0) begin
          report_mismatch("unexpected result", out_quotient, '0);
        end else begin
          want = quotients_due.pop_front();
          if (out_quotient !== want.quotient)
            report_mismatch("quotient", out_quotient, want.quotient);
          if (out_divide_by_zero !== want.divide_by_zero)
            report_mismatch("divide_by_zero", word_t'(out_divide_by_zero),
                            word_t'(want.divide_by_zero));
          if (out_overflow !== want.overflow)
            report_mismatch("overflow", word_t'(out_overflow), word_t'(want.overflow));
          if (want.divide_by_zero) zero_divides++;
          if (want.overflow) overflows++;
        end
        // Start the hold-off once, while the sender still has plenty to offer.
        if (!hold_done && results_seen == HOLD_AT) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm_phase && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_400_000;
    $display("Timeout with %0d results still outstanding.", quotients_due.size());
    $display("signed_shift_subtract_divider verification failed");
    $finish;
  end

endmodule

// ===== signed_shift_subtract_divider.f =====
rtl/ssd_pkg.sv
rtl/ssd_stage.sv
rtl/signed_shift_subtract_divider.sv
dv/tb.sv
